// ===== rtl/tbst_pkg.sv =====
// Shared types and constants for the timed ban set table.
package tbst_pkg;

  localparam int KEY_W = 32;
  localparam int STAMP_W = 64;
  localparam int IDX_W = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_ADD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BAN_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_ON_HIT = 1'b1;

  typedef enum logic [2:0] {
    ST_PRESENT = 3'd0,
    ST_ABSENT  = 3'd1,
    ST_EXPIRED = 3'd2,
    ST_ADDED   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic clear;
  } tbst_cmd_t;

  typedef struct packed {
    logic clear_last;
  } tbst_stat_t;

endpackage

// ===== rtl/tbst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tbst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tbst_ctl.sv =====
// Controller: clearing pass, request accept and bucket update sequencing.
module tbst_ctl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  tbst_pkg::tbst_stat_t stat,
  output tbst_pkg::tbst_cmd_t  cmd
);
  import tbst_pkg::*;

  ctl_state_t state, state_next;
  logic       rsp_valid_next;
  logic       fire;

  assign fire = (state == S_EXEC) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (stat.clear_last) state_next = S_IDLE;
      S_IDLE:  if (req_valid) state_next = S_EXEC;
      S_EXEC:  if (fire) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    req_ready  = (state == S_IDLE);
    cmd.accept = (state == S_IDLE) && req_valid;
    cmd.exec   = fire;
    cmd.clear  = (state == S_CLEAR);
    if (fire) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// ===== rtl/tbst_dp.sv =====
// Datapath: bucket memories, per-way compare and aging, row update, result.
module tbst_dp #(
  parameter int BUCKETS = 1024,
  parameter int WAYS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tbst_pkg::tbst_cmd_t            cmd,
  output tbst_pkg::tbst_stat_t           stat,
  input  logic                          cfg_we,
  input  logic [tbst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbst_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          command,
  input  logic [tbst_pkg::KEY_W-1:0]      key,
  input  logic [tbst_pkg::IDX_W-1:0]      bucket_index,
  input  logic [tbst_pkg::STAMP_W-1:0]    now,
  output logic [2:0]                    status,
  output logic [2:0]                    way
);
  import tbst_pkg::*;

  localparam int ROW_W = $clog2(BUCKETS);
  localparam int EXT_W = (ROW_W > IDX_W) ? ROW_W : IDX_W;
  localparam int KROW_W = WAYS * KEY_W;
  localparam int SROW_W = WAYS * STAMP_W;

  logic [STAMP_W-1:0] ban_time;
  logic               refresh_on_hit;

  logic               cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [STAMP_W-1:0] now_q;
  logic [ROW_W-1:0]   bucket_q;
  logic [ROW_W-1:0]   bucket;
  logic [ROW_W-1:0]   clear_row;

  logic [KROW_W-1:0]  rd_keys, new_keys, wr_keys;
  logic [SROW_W-1:0]  rd_stamps, new_stamps, wr_stamps;
  logic [ROW_W-1:0]   waddr;
  logic               we;

  logic [WAYS-1:0]    match, expd, hit_oh, exp_oh, key_oh, stamp_oh;
  logic               hit, exp_any, exp_hit;
  logic [2:0]         hit_way, exp_way;
  logic [KEY_W-1:0]   k_val;
  logic [STAMP_W-1:0] s_val;
  status_t            st_next, status_q;
  logic [2:0]         way_next, way_q;

  // Bucket index modulo BUCKETS
  logic [EXT_W-1:0] idx_ext;
  assign idx_ext = EXT_W'(bucket_index);

  generate
    if (((BUCKETS & (BUCKETS - 1)) == 0) || (BUCKETS >= (1 << IDX_W))) begin : g_mask
      assign bucket = idx_ext[ROW_W-1:0];
    end else begin : g_recip
      localparam int unsigned RECIP = (1 << 20) / BUCKETS + 1;
      logic [29:0] prod;
      logic [19:0] qb;
      logic [IDX_W-1:0] rem;
      assign prod = 30'(bucket_index) * 30'(RECIP);
      assign qb = 20'(prod[29:20]) * 20'(BUCKETS);
      assign rem = bucket_index - qb[IDX_W-1:0];
      assign bucket = rem[ROW_W-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      ban_time       <= '0;
      refresh_on_hit <= 1'b0;
      clear_row      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BAN_TIME:       ban_time <= cfg_data;
          CFG_REFRESH_ON_HIT: refresh_on_hit <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.clear) begin
        clear_row <= clear_row + 1'b1;
      end
    end
  end

  assign stat.clear_last = (clear_row == ROW_W'(BUCKETS - 1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q    <= command;
      key_q    <= key;
      now_q    <= now;
      bucket_q <= bucket;
    end
    if (cmd.exec) begin
      status_q <= st_next;
      way_q    <= way_next;
    end
  end

  assign we        = cmd.exec || cmd.clear;
  assign waddr     = cmd.clear ? clear_row : bucket_q;
  assign wr_keys   = cmd.clear ? '0 : new_keys;
  assign wr_stamps = cmd.clear ? '0 : new_stamps;

  tbst_ram #(.WIDTH(KROW_W), .DEPTH(BUCKETS)) u_key_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_keys),
    .re    (cmd.accept),
    .raddr (bucket),
    .rdata (rd_keys)
  );

  tbst_ram #(.WIDTH(SROW_W), .DEPTH(BUCKETS)) u_stamp_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_stamps),
    .re    (cmd.accept),
    .raddr (bucket),
    .rdata (rd_stamps)
  );

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match[i] = (rd_keys[i*KEY_W +: KEY_W] == key_q);
      expd[i]  = (now_q - rd_stamps[i*STAMP_W +: STAMP_W]) > ban_time;
    end
  end

  // Lowest matching and lowest expired way
  always_comb begin
    hit     = 1'b0;
    exp_any = 1'b0;
    hit_oh  = '0;
    exp_oh  = '0;
    hit_way = 3'd0;
    exp_way = 3'd0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_oh  = WAYS'(1) << i;
        hit_way = 3'(i);
      end
      if (expd[i]) begin
        exp_any = 1'b1;
        exp_oh  = WAYS'(1) << i;
        exp_way = 3'(i);
      end
    end
    exp_hit = |(hit_oh & expd);
  end

  always_comb begin
    k_val    = key_q;
    s_val    = now_q;
    key_oh   = '0;
    stamp_oh = '0;
    st_next  = ST_ABSENT;
    way_next = 3'd0;
    if (cmd_q == CMD_LOOKUP) begin
      if (hit) begin
        way_next = hit_way;
        if (exp_hit) begin
          st_next  = ST_EXPIRED;
          key_oh   = hit_oh;
          stamp_oh = hit_oh;
          k_val    = '0;
          s_val    = '0;
        end else begin
          st_next = ST_PRESENT;
          if (refresh_on_hit) stamp_oh = hit_oh;
        end
      end
    end else begin
      if (hit) begin
        st_next  = ST_PRESENT;
        way_next = hit_way;
        stamp_oh = hit_oh;
      end else if (exp_any) begin
        st_next  = ST_ADDED;
        way_next = exp_way;
        key_oh   = exp_oh;
        stamp_oh = exp_oh;
      end else begin
        st_next = ST_FULL;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      new_keys[i*KEY_W +: KEY_W] = key_oh[i] ? k_val : rd_keys[i*KEY_W +: KEY_W];
      new_stamps[i*STAMP_W +: STAMP_W] =
        stamp_oh[i] ? s_val : rd_stamps[i*STAMP_W +: STAMP_W];
    end
  end

  assign status = status_q;
  assign way    = way_q;

endmodule

// ===== rtl/timed_ban_set_table.sv =====
// Timed ban set table: set-associative key table with per-slot aging.
// For each request the bucket row is read through the registered
// RAM port when it is accepted, then compared and written back in the execute state.
// The result is registered at write-back; the execute state waits while an earlier
// result is still held unread, and no new request is accepted until it completes.
// Reset runs a clearing pass over all BUCKETS rows with req_ready low.
module timed_ban_set_table #(
  parameter int BUCKETS = 1024,
  parameter int WAYS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tbst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbst_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic                          command,
  input  logic [tbst_pkg::KEY_W-1:0]      key,
  input  logic [tbst_pkg::IDX_W-1:0]      bucket_index,
  input  logic [tbst_pkg::STAMP_W-1:0]    now,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [2:0]                    status,
  output logic [2:0]                    way
);
  import tbst_pkg::*;

  tbst_cmd_t  cmd;
  tbst_stat_t stat;

  tbst_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tbst_dp #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .command      (command),
    .key          (key),
    .bucket_index (bucket_index),
    .now          (now),
    .status       (status),
    .way          (way)
  );

endmodule
